@@ design/mean_kth_nearest_distance_core_macros.svh @@
// assertion helpers shared by the rtl, sampled on clk and quiet while rst_n is low
`ifndef MEAN_KTH_NEAREST_DISTANCE_CORE_MACROS_SVH
`define MEAN_KTH_NEAREST_DISTANCE_CORE_MACROS_SVH

// same-cycle implication
`define MKND_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MKND_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mknd_pkg.sv @@
package mknd_pkg;

  localparam int DIST_W        = 32;
  localparam int CFG_W         = 9;
  localparam int CFG_IDX_W     = 2;
  localparam int MAX_ITEMS_DEF = 256;
  localparam int DIST_BITS_DEF = 32;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [CFG_W-1:0] ITEM_COUNT_RST   = 9'd256;
  localparam logic [CFG_W-1:0] TARGET_COUNT_RST = 9'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ITEM_COUNT   = 2'd0,
    REG_TARGET_COUNT = 2'd1
  } cfg_reg_t;

  // classification of one queued item
  typedef struct packed {
    logic row_end;
    logic mat_end;
  } mknd_tag_t;

  // front to back control
  typedef struct packed {
    logic restart;
    logic active;
  } mknd_ctl_t;

  // divider status seen by one requester
  typedef struct packed {
    logic gnt;
    logic done;
  } mknd_div_st_t;

  // stored distance width
  function automatic int val_w(int dist_bits);
    return (dist_bits < DIST_W) ? dist_bits : DIST_W;
  endfunction

  // width of a count that can hold max_items itself
  function automatic int cnt_w(int max_items);
    return $clog2(max_items + 1);
  endfunction

endpackage

@@ design/mknd_div.sv @@
module mknd_div #(
  parameter int DVD_W = 41,
  parameter int DVS_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);
  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  // one quotient bit a cycle, restoring
  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign rem_nxt = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= dividend_i;
      rem_r <= '0;
      dvs_r <= divisor_i;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy_o     = busy_r;
  assign done_o     = done_r;
  assign quotient_o = quo_r;

endmodule

@@ design/mknd_fifo.sv @@
module mknd_fifo #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             flush_i,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             empty_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_r;
  logic [AW-1:0]    rd_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full_o  = cnt_r == CW'(DEPTH);
  assign empty_o = cnt_r == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n || flush_i) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      priority if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din_i;
    end
  end

endmodule

@@ design/mknd_front.sv @@
module mknd_front #(
  parameter int MAX_ITEMS = mknd_pkg::MAX_ITEMS_DEF,
  parameter int DIST_BITS = mknd_pkg::DIST_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_push,
  output logic                                        in_full,
  input  logic [mknd_pkg::DIST_W-1:0]                 in_distance,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [mknd_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [mknd_pkg::CFG_W-1:0]                  cfg_data,
  input  logic                                        fifo_full_i,
  output logic                                        fifo_push_o,
  output logic [$bits(mknd_pkg::mknd_tag_t)+mknd_pkg::val_w(DIST_BITS)-1:0] fifo_data_o,
  output mknd_pkg::mknd_ctl_t                         ctl_o,
  output logic [mknd_pkg::cnt_w(MAX_ITEMS)-1:0]       m_o,
  output logic [mknd_pkg::cnt_w(MAX_ITEMS)-1:0]       n_eff_o,
  output logic [mknd_pkg::CFG_W-1:0]                  t_eff_o,
  output logic                                        div_req_o,
  input  mknd_pkg::mknd_div_st_t                      div_st_i,
  input  logic [mknd_pkg::cnt_w(MAX_ITEMS)-1:0]       div_q_i
);
  import mknd_pkg::*;

  localparam int CNT_W = cnt_w(MAX_ITEMS);
  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int VAL_W = val_w(DIST_BITS);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0] item_count_r;
  logic [CFG_W-1:0] target_count_r;
  logic [CNT_W-1:0] m_r;
  logic             m_pend_r;
  logic             m_wait_r;
  logic [IDX_W-1:0] col_r;
  logic [IDX_W-1:0] row_r;

  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] n_last;
  logic [IDX_W-1:0] last_idx;
  logic [CFG_W-1:0] t_eff;
  logic             active;
  logic             accept;
  logic             cfg_wr;
  logic             cfg_hit;
  mknd_tag_t        tag;

  always_comb begin
    priority if (item_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (CMP_W'(item_count_r) > CMP_W'(MAX_ITEMS)) begin
      n_eff = CNT_W'(MAX_ITEMS);
    end else begin
      n_eff = CNT_W'(item_count_r);
    end
  end

  assign t_eff    = (target_count_r == '0) ? CFG_W'(1) : target_count_r;
  assign active   = CMP_W'(t_eff) < CMP_W'(n_eff);
  assign n_last   = n_eff - CNT_W'(1);
  assign last_idx = n_last[IDX_W-1:0];

  assign tag.row_end = col_r == last_idx;
  assign tag.mat_end = tag.row_end && (row_r == last_idx);

  // no items until the rank is known
  assign in_full   = fifo_full_i || m_pend_r || m_wait_r;
  assign accept    = in_push && !in_full;
  assign cfg_ready = !m_pend_r && !m_wait_r;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_wr && ((cfg_index == REG_ITEM_COUNT) ||
                                (cfg_index == REG_TARGET_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r   <= ITEM_COUNT_RST;
      target_count_r <= TARGET_COUNT_RST;
      m_r            <= '0;
      m_pend_r       <= 1'b1;
      m_wait_r       <= 1'b0;
      col_r          <= '0;
      row_r          <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_ITEM_COUNT:   item_count_r   <= cfg_data;
          REG_TARGET_COUNT: target_count_r <= cfg_data;
          default: ;
        endcase
      end
      if (div_st_i.gnt) begin
        m_pend_r <= 1'b0;
        m_wait_r <= 1'b1;
      end
      if (div_st_i.done && m_wait_r) begin
        m_wait_r <= 1'b0;
        m_r      <= div_q_i;
      end
      if (cfg_hit) begin
        col_r    <= '0;
        row_r    <= '0;
        m_pend_r <= 1'b1;
      end else if (accept) begin
        if (tag.row_end) begin
          col_r <= '0;
          row_r <= tag.mat_end ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  assign fifo_push_o    = accept;
  assign fifo_data_o    = {tag, in_distance[VAL_W-1:0]};
  assign ctl_o.restart  = cfg_hit;
  assign ctl_o.active   = active;
  assign m_o            = m_r;
  assign n_eff_o        = n_eff;
  assign t_eff_o        = t_eff;
  assign div_req_o      = m_pend_r;

endmodule

@@ design/mknd_back.sv @@
`include "mean_kth_nearest_distance_core_macros.svh"

module mknd_back #(
  parameter int MAX_ITEMS = mknd_pkg::MAX_ITEMS_DEF,
  parameter int DIST_BITS = mknd_pkg::DIST_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mknd_pkg::mknd_ctl_t                   ctl_i,
  input  logic [mknd_pkg::cnt_w(MAX_ITEMS)-1:0] m_i,
  input  logic                                  fifo_empty_i,
  input  logic [$bits(mknd_pkg::mknd_tag_t)+mknd_pkg::val_w(DIST_BITS)-1:0] fifo_data_i,
  output logic                                  fifo_pop_o,
  output logic                                  div_req_o,
  output logic [mknd_pkg::val_w(DIST_BITS)+mknd_pkg::cnt_w(MAX_ITEMS)-1:0] div_dvd_o,
  input  mknd_pkg::mknd_div_st_t                div_st_i,
  input  logic [mknd_pkg::val_w(DIST_BITS)+mknd_pkg::cnt_w(MAX_ITEMS)-1:0] div_q_i,
  input  logic                                  out_pop,
  output logic                                  out_empty,
  output logic [mknd_pkg::DIST_W-1:0]           out_radius
);
  import mknd_pkg::*;

  localparam int VAL_W = val_w(DIST_BITS);
  localparam int CNT_W = cnt_w(MAX_ITEMS);
  localparam int SUM_W = VAL_W + CNT_W;
  localparam int TAG_W = $bits(mknd_tag_t);

  // sorted row store, largest kept value in entry 0
  logic [VAL_W-1:0]     store_r    [MAX_ITEMS];
  logic [VAL_W-1:0]     store_nxt  [MAX_ITEMS];
  logic [VAL_W-1:0]     store_prev [MAX_ITEMS];
  logic [VAL_W-1:0]     store_next [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] valid_r;
  logic [MAX_ITEMS-1:0] valid_nxt;
  logic [MAX_ITEMS-1:0] valid_prev;
  logic [MAX_ITEMS-1:0] gt;
  logic [MAX_ITEMS-1:0] gt_prev;
  logic [MAX_ITEMS-1:0] gt_next;
  logic [CNT_W-1:0]     cnt_r;

  logic [VAL_W-1:0]     kth_r;
  logic                 add_v_r;
  logic                 fin_v_r;
  logic [SUM_W-1:0]     rank_sum_r;
  logic [SUM_W-1:0]     final_sum_r;
  logic                 div_pend_r;
  logic                 res_wait_r;
  logic                 out_valid_r;
  logic [DIST_W-1:0]    radius_r;

  mknd_tag_t            tag;
  logic [VAL_W-1:0]     v;
  logic                 fin_busy;
  logic                 pop;
  logic                 ins;
  logic                 full;
  logic [SUM_W-1:0]     kth_ext;

  assign tag = mknd_tag_t'(fifo_data_i[VAL_W +: TAG_W]);
  assign v   = fifo_data_i[VAL_W-1:0];

  // one matrix result in flight at a time
  assign fin_busy = fin_v_r || div_pend_r || res_wait_r || out_valid_r;
  assign pop      = !fifo_empty_i && !(tag.mat_end && fin_busy);
  assign ins      = pop && ctl_i.active;
  assign full     = cnt_r == m_i;
  assign kth_ext  = SUM_W'(kth_r);

  for (genvar gi = 0; gi < MAX_ITEMS; gi++) begin : g_nb
    assign gt[gi] = valid_r[gi] && (store_r[gi] > v);
    if (gi == 0) begin : g_first
      assign store_prev[gi] = '0;
    end else begin : g_prev
      assign store_prev[gi] = store_r[gi-1];
    end
    if (gi == MAX_ITEMS - 1) begin : g_last
      assign store_next[gi] = '0;
    end else begin : g_next
      assign store_next[gi] = store_r[gi+1];
    end
  end

  assign gt_prev    = {gt[MAX_ITEMS-2:0], 1'b1};
  assign gt_next    = {1'b0, gt[MAX_ITEMS-1:1]};
  assign valid_prev = {valid_r[MAX_ITEMS-2:0], 1'b1};
  assign valid_nxt  = full ? valid_r : (valid_r | valid_prev);

  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (full) begin
        // drop the largest, larger ones move toward entry 0
        store_nxt[i] = gt[i] ? (gt_next[i] ? store_next[i] : v) : store_r[i];
      end else if (!gt[i]) begin
        store_nxt[i] = gt_prev[i] ? v : (valid_prev[i] ? store_prev[i] : store_r[i]);
      end else begin
        store_nxt[i] = store_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cnt_r       <= '0;
      add_v_r     <= 1'b0;
      fin_v_r     <= 1'b0;
      rank_sum_r  <= '0;
      div_pend_r  <= 1'b0;
      res_wait_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl_i.restart) begin
        valid_r    <= '0;
        cnt_r      <= '0;
        add_v_r    <= 1'b0;
        fin_v_r    <= 1'b0;
        rank_sum_r <= '0;
        div_pend_r <= 1'b0;
        res_wait_r <= 1'b0;
      end else begin
        if (ins) begin
          if (tag.row_end) begin
            valid_r <= '0;
            cnt_r   <= '0;
          end else begin
            valid_r <= valid_nxt;
            cnt_r   <= full ? cnt_r : cnt_r + 1'b1;
          end
        end
        add_v_r <= ins && tag.row_end;
        fin_v_r <= pop && tag.mat_end;
        if (fin_v_r) begin
          rank_sum_r <= '0;
          div_pend_r <= 1'b1;
        end else if (add_v_r) begin
          rank_sum_r <= rank_sum_r + kth_ext;
        end
        if (div_st_i.gnt) begin
          div_pend_r <= 1'b0;
          res_wait_r <= 1'b1;
        end
        if (div_st_i.done && res_wait_r) begin
          res_wait_r <= 1'b0;
        end
      end
      if (div_st_i.done && res_wait_r && !ctl_i.restart) begin
        out_valid_r <= 1'b1;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      store_r <= store_nxt;
    end
    if (ins && tag.row_end) begin
      kth_r <= store_nxt[0];
    end
    if (fin_v_r) begin
      final_sum_r <= rank_sum_r + (add_v_r ? kth_ext : '0);
    end
    if (div_st_i.done && res_wait_r) begin
      radius_r <= DIST_W'(div_q_i[VAL_W-1:0]);
    end
  end

  assign fifo_pop_o = pop;
  assign div_req_o  = div_pend_r;
  assign div_dvd_o  = final_sum_r;
  assign out_empty  = !out_valid_r;
  assign out_radius = radius_r;

  `MKND_ASSERT_IMP(a_cnt_match, 1'b1, $countones(valid_r) == int'(cnt_r), "kept count off")
  `MKND_ASSERT_IMP(a_thermo, 1'b1, (MAX_ITEMS'(valid_r + 1'b1) & valid_r) == '0, "store gap")
  `MKND_ASSERT_IMP(a_cnt_le_m, ctl_i.active, cnt_r <= m_i, "store beyond rank")
  `MKND_ASSERT_NXT(a_fin_pend, fin_v_r && !ctl_i.restart, div_pend_r, "final sum lost")

endmodule

@@ design/mean_kth_nearest_distance_core.sv @@
// throughput: one distance item a cycle while full is low; full is high after reset and
//   each register write while m = N/n is divided out, and a matrix end waits in the queue
//   while the previous radius is still being divided or is unread
// reset: rst_n low at a clock edge restores item_count 256 and target_count 1 and clears the
//   counters, the sum, the queue and the result valid flag
`include "mean_kth_nearest_distance_core_macros.svh"

module mean_kth_nearest_distance_core #(
  parameter int MAX_ITEMS = mknd_pkg::MAX_ITEMS_DEF,
  parameter int DIST_BITS = mknd_pkg::DIST_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [mknd_pkg::DIST_W-1:0]    in_distance,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [mknd_pkg::DIST_W-1:0]    out_radius,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mknd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mknd_pkg::CFG_W-1:0]     cfg_data
);
  import mknd_pkg::*;

  localparam int VAL_W = val_w(DIST_BITS);
  localparam int CNT_W = cnt_w(MAX_ITEMS);
  localparam int SUM_W = VAL_W + CNT_W;
  // divisor is either the target count or the item count
  localparam int DVS_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  // queue entry: classification tag above the masked distance
  localparam int QW    = $bits(mknd_tag_t) + VAL_W;

  // front to queue
  logic             q_push;
  logic [QW-1:0]    q_din;
  logic             q_full;
  // queue to back
  logic             q_pop;
  logic [QW-1:0]    q_dout;
  logic             q_empty;

  mknd_ctl_t        ctl;
  logic [CNT_W-1:0] m_rank;
  logic [CNT_W-1:0] n_eff;
  logic [CFG_W-1:0] t_eff;

  // shared divider and its two requesters
  logic             f_req;
  logic             b_req;
  logic             f_gnt;
  logic             b_gnt;
  logic [SUM_W-1:0] b_dvd;
  mknd_div_st_t     f_st;
  mknd_div_st_t     b_st;
  logic             div_start;
  logic [SUM_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_busy;
  logic             div_done;
  logic [SUM_W-1:0] div_q;

  // front: config registers, row and column counters, tags each item with its row or
  // matrix end and computes the effective sizes
  mknd_front #(
    .MAX_ITEMS (MAX_ITEMS),
    .DIST_BITS (DIST_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_distance (in_distance),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fifo_full_i (q_full),
    .fifo_push_o (q_push),
    .fifo_data_o (q_din),
    .ctl_o       (ctl),
    .m_o         (m_rank),
    .n_eff_o     (n_eff),
    .t_eff_o     (t_eff),
    .div_req_o   (f_req),
    .div_st_i    (f_st),
    .div_q_i     (div_q[CNT_W-1:0])
  );

  // short queue so the back end may stall on a matrix end without holding up the input;
  // a write to item_count or target_count empties it
  mknd_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .flush_i (ctl.restart),
    .push_i  (q_push),
    .din_i   (q_din),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .dout_o  (q_dout),
    .empty_o (q_empty)
  );

  // back: insertion chain keeping the m smallest of the row, row sum and result register
  mknd_back #(
    .MAX_ITEMS (MAX_ITEMS),
    .DIST_BITS (DIST_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl_i        (ctl),
    .m_i          (m_rank),
    .fifo_empty_i (q_empty),
    .fifo_data_i  (q_dout),
    .fifo_pop_o   (q_pop),
    .div_req_o    (b_req),
    .div_dvd_o    (b_dvd),
    .div_st_i     (b_st),
    .div_q_i      (div_q),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_radius   (out_radius)
  );

  // rank computation wins over the mean; in practice they never collide
  assign f_gnt     = f_req && !div_busy;
  assign b_gnt     = b_req && !div_busy && !f_req;
  assign div_start = f_gnt || b_gnt;
  assign div_dvd   = f_gnt ? SUM_W'(n_eff) : b_dvd;
  assign div_dvs   = f_gnt ? DVS_W'(t_eff) : DVS_W'(n_eff);

  assign f_st.gnt  = f_gnt;
  assign f_st.done = div_done;
  assign b_st.gnt  = b_gnt;
  assign b_st.done = div_done;

  mknd_div #(
    .DVD_W (SUM_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  `MKND_ASSERT_IMP(a_div_idle_start, div_start, !div_busy, "divider restarted while busy")

endmodule

@@ test/mknd_radius_checker.sv @@
module mknd_radius_checker #(
  parameter int MAX_ITEMS = mknd_pkg::MAX_ITEMS_DEF,
  parameter int DIST_BITS = mknd_pkg::DIST_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic                           in_full,
  input  logic [mknd_pkg::DIST_W-1:0]    in_distance,
  input  logic                           out_empty,
  input  logic                           out_pop,
  input  logic [mknd_pkg::DIST_W-1:0]    out_radius,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mknd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mknd_pkg::CFG_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             radii_checked
);
  import mknd_pkg::*;

  localparam logic [63:0] DIST_MASK = (DIST_BITS >= 64) ? '1 : ((64'd1 << DIST_BITS) - 64'd1);

  logic [CFG_W-1:0]  item_count_q;
  logic [CFG_W-1:0]  target_count_q;
  logic [DIST_W-1:0] row_smallest [MAX_ITEMS];
  int unsigned       col_pos;
  int unsigned       row_pos;
  int unsigned       kept_n;
  logic [63:0]       rank_total;
  logic [DIST_W-1:0] radius_due [$];
  logic [DIST_W-1:0] radius_want;

  function automatic int unsigned effective_items();
    int unsigned n;
    n = 32'(item_count_q);
    if (n == 0) n = 1;
    if (n > MAX_ITEMS) n = MAX_ITEMS;
    return n;
  endfunction

  function automatic int unsigned effective_target();
    return (target_count_q == 0) ? 1 : 32'(target_count_q);
  endfunction

  task automatic report_fault(input string msg);
    fail_count++;
    $display("[%0t] %s", $realtime, msg);
  endtask

  task automatic restart_matrix();
    col_pos    = 0;
    row_pos    = 0;
    rank_total = '0;
    kept_n     = 0;
  endtask

  // sorted insertion keeping at most m values, ties stay in arrival order
  task automatic keep_if_smaller(input logic [DIST_W-1:0] v, input int unsigned m);
    int unsigned pos;
    bit          keep;
    keep = (m != 0) && (m <= MAX_ITEMS);
    if (keep && kept_n >= m) begin
      if (v >= row_smallest[m-1]) keep = 0;
      else kept_n = m - 1;
    end
    if (keep) begin
      pos = kept_n;
      while (pos > 0 && row_smallest[pos-1] > v) begin
        row_smallest[pos] = row_smallest[pos-1];
        pos--;
      end
      row_smallest[pos] = v;
      kept_n++;
    end
  endtask

  task automatic absorb_distance(input logic [DIST_W-1:0] d);
    int unsigned       n_items;
    int unsigned       n_target;
    int unsigned       m;
    bit                active;
    logic [DIST_W-1:0] v;
    logic [63:0]       mean;
    n_items  = effective_items();
    n_target = effective_target();
    active   = n_target < n_items;
    m        = active ? n_items / n_target : 0;
    v        = d & DIST_MASK[DIST_W-1:0];
    if (active) keep_if_smaller(v, m);
    if (col_pos + 1 >= n_items) begin
      if (active && kept_n >= m && m >= 1) rank_total += 64'(row_smallest[m-1]);
      kept_n  = 0;
      col_pos = 0;
      if (row_pos + 1 >= n_items) begin
        mean = active ? rank_total / 64'(n_items) : '0;
        radius_due.push_back(mean[DIST_W-1:0]);
        restart_matrix();
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endtask

  task automatic load_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    if (idx == REG_ITEM_COUNT) begin
      item_count_q = data;
      restart_matrix();
    end else if (idx == REG_TARGET_COUNT) begin
      target_count_q = data;
      restart_matrix();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      item_count_q   = ITEM_COUNT_RST;
      target_count_q = TARGET_COUNT_RST;
      restart_matrix();
      radius_due.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (radius_due.size() == 0) begin
          report_fault($sformatf("radius %08h with none expected", out_radius));
        end else begin
          radius_want = radius_due.pop_front();
          if (out_radius !== radius_want)
            report_fault($sformatf("radius %08h, expected %08h", out_radius, radius_want));
          radii_checked++;
        end
      end
      if (cfg_valid && cfg_ready) load_register(cfg_index, cfg_data);
      if (in_push && !in_full) absorb_distance(in_distance);
    end
    pending = radius_due.size();
  end

endmodule

@@ test/mean_kth_nearest_distance_core_tb.sv @@
module mean_kth_nearest_distance_core_tb;
  import mknd_pkg::*;

  localparam int CLK_PERIOD    = 4;
  // longer than the radius division and the rank division
  localparam int SETTLE_CYCLES = 60;
  localparam int DRAIN_CYCLES  = 100;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_CYCLES  = 400000;

  // register indexes past the end of the list, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum int {FILL_RANDOM, FILL_CLUSTERED, FILL_ZERO_DIAG, FILL_EXTREME} fill_style_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  logic [DIST_W-1:0]    in_distance;
  logic                 out_empty;
  logic                 out_pop;
  logic [DIST_W-1:0]    out_radius;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int chk_fails;
  int chk_pending;
  int chk_radii;

  // idling knobs, percentages per cycle
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  // long receiver hold-off, counted down by the receiver itself
  int hold_cycles   = 0;

  int items_sent  = 0;
  int writes_done = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  mean_kth_nearest_distance_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_distance (in_distance),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_radius  (out_radius),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  mknd_radius_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_distance   (in_distance),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_radius    (out_radius),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (chk_fails),
    .pending       (chk_pending),
    .radii_checked (chk_radii)
  );

  // receiver side: random stalls, or a long hold when one is asked for
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_pop <= 1'b0;
        hold_cycles--;
      end else begin
        out_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  // watchdog
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("timed out with %0d radii outstanding", chk_pending);
    $display("Verification failed");
    $finish;
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        pop_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 48;
        pop_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        pop_stall_pct = 48;
      end
      default: begin
        send_idle_pct = 6;
        pop_stall_pct = 6;
      end
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic push_distance(input logic [DIST_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push     <= 1'b1;
    in_distance <= d;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // drop push, let every expected radius out, then give the block time to go quiet
  task automatic settle();
    in_push <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    settle();
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    writes_done++;
  endtask

  function automatic logic [DIST_W-1:0] pick_distance(input fill_style_t style,
                                                      input bit on_diag);
    case (style)
      FILL_RANDOM:    return $urandom;
      // a handful of values, so ties are everywhere
      FILL_CLUSTERED: return $urandom_range(7);
      // realistic matrix: zero diagonal, distances up to a few hundred units
      FILL_ZERO_DIAG: return on_diag ? '0 : (($urandom_range(300) << 16) | ($urandom & 32'hFFFF));
      default: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return DIST_MAX;
          2:       return 32'h1 << $urandom_range(31);
          default: return ~(32'h1 << $urandom_range(31));
        endcase
      end
    endcase
  endfunction

  initial begin : stimulus
    int          sel;
    int          mats;
    int          split;
    int          count;
    int          neff;
    int          rand_start;
    int          round;
    logic [8:0]  cur_items;
    logic [8:0]  cur_target;
    fill_style_t style;

    rst_n       = 1'b0;
    in_push     = 1'b0;
    in_distance = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_ITEM_COUNT;
    cfg_data    = '0;
    cur_items   = ITEM_COUNT_RST;
    cur_target  = TARGET_COUNT_RST;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part ----
    // reset settings (256 items, target 1): start a matrix that never finishes
    push_distance('0);
    push_distance(DIST_MAX);
    push_distance(32'hAAAA_AAAA);
    push_distance(32'h5555_5555);

    // two items, rank 2: a full row, then a rewrite of the same target value restarts
    write_register(REG_ITEM_COUNT, 9'd2);
    push_distance(DIST_MAX);
    push_distance(DIST_MAX);
    write_register(REG_TARGET_COUNT, 9'd1);
    // all-ones matrix gives the largest radius
    repeat (4) push_distance(DIST_MAX);

    // three items, rank 3, ties; a write to a spare index mid-matrix must not restart
    write_register(REG_ITEM_COUNT, 9'd3);
    push_distance(32'd5);
    push_distance(32'd5);
    write_register(CFG_IDX_SPARE_LO, 9'h1FF);
    push_distance(32'd0);
    push_distance(32'd5);
    push_distance(32'd7);
    push_distance(32'd7);
    push_distance(32'd7);
    push_distance(32'd0);
    push_distance(32'd0);

    // zero count and zero target both read as one: every item is a zero radius
    write_register(REG_ITEM_COUNT, 9'd0);
    write_register(REG_TARGET_COUNT, 9'd0);
    push_distance(DIST_MAX);
    push_distance(32'h8000_0000);

    // count past the store size saturates, rank 1; spare high index ignored
    write_register(REG_ITEM_COUNT, 9'h1FF);
    write_register(REG_TARGET_COUNT, 9'd255);
    write_register(CFG_IDX_SPARE_HI, 9'd0);
    push_distance(32'h0001_0000);
    push_distance(32'd1);
    push_distance('0);

    // ---- pressure: receiver holds off while two-item matrices keep coming ----
    set_idling(IDLE_NONE);
    write_register(REG_ITEM_COUNT, 9'd2);
    write_register(REG_TARGET_COUNT, 9'd1);
    cur_items  = 9'd2;
    cur_target = 9'd1;
    hold_cycles = HOLD_CYCLES;
    repeat (60) push_distance(pick_distance(FILL_RANDOM, 1'b0));
    settle();

    // ---- random part ----
    rand_start = items_sent;
    round      = 0;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      set_idling(idle_mode_t'((round / 3) % 4));

      // item count: mostly small matrices so radii keep coming
      sel = $urandom_range(99);
      if (sel < 70)      cur_items = 9'($urandom_range(8, 2));
      else if (sel < 85) cur_items = 9'($urandom_range(16, 9));
      else if (sel < 90) cur_items = 9'($urandom_range(1));
      else if (sel < 95) cur_items = 9'($urandom_range(511, 257));
      else               cur_items = 9'($urandom_range(256, 200));
      neff = (cur_items == 0) ? 1 : ((cur_items > MAX_ITEMS_DEF) ? MAX_ITEMS_DEF : cur_items);

      // target: rank N, any rank, zero, and at or above the count
      sel = $urandom_range(99);
      if (sel < 40)      cur_target = 9'd1;
      else if (sel < 65) cur_target = 9'($urandom_range((neff > 1) ? neff - 1 : 1, 1));
      else if (sel < 75) cur_target = 9'd0;
      else if (sel < 85) cur_target = 9'(neff);
      else if (sel < 92) cur_target = 9'((neff + 10 > 511) ? 511 : neff + $urandom_range(10, 1));
      else               cur_target = 9'($urandom_range(511));

      // now and then only one register changes
      sel = $urandom_range(9);
      if (sel != 0) write_register(REG_ITEM_COUNT, cur_items);
      if (sel != 1) write_register(REG_TARGET_COUNT, cur_target);
      if (sel == 0 && round == 0) write_register(REG_ITEM_COUNT, cur_items);

      if (neff > 16) begin
        // large sizes see between 20 and 300 items before the next write
        style = fill_style_t'($urandom_range(3));
        count = $urandom_range(300, 20);
        for (int k = 0; k < count; k++)
          push_distance(pick_distance(style, (k % neff) == ((k / neff) % neff)));
      end else begin
        mats = $urandom_range(3, 1);
        for (int j = 0; j < mats; j++) begin
          style = fill_style_t'($urandom_range(3));
          split = ($urandom_range(9) == 0) ? $urandom_range(neff * neff - 1) : -1;
          for (int k = 0; k < neff * neff; k++) begin
            if (k == split) write_register($urandom_range(1) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI,
                                           9'($urandom_range(511)));
            push_distance(pick_distance(style, (k / neff) == (k % neff)));
          end
        end
        // broken matrix: a partial one, cut short by the next register write
        if (neff > 1 && $urandom_range(99) < 15) begin
          style = fill_style_t'($urandom_range(3));
          count = $urandom_range(neff * neff - 1, 1);
          for (int k = 0; k < count; k++)
            push_distance(pick_distance(style, (k / neff) == (k % neff)));
        end
      end
      round++;
    end

    // ---- drain ----
    set_idling(IDLE_NONE);
    in_push <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run covered %0d distance items, %0d register writes, %0d radii checked",
             items_sent, writes_done, chk_radii);
    $display("counts 1 to 256 with saturation, targets 0 to 511, four idling mixes, one long hold");
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/mknd_pkg.sv
design/mknd_div.sv
design/mknd_fifo.sv
design/mknd_front.sv
design/mknd_back.sv
design/mean_kth_nearest_distance_core.sv
test/mknd_radius_checker.sv
test/mean_kth_nearest_distance_core_tb.sv
